/* rtl/core/spbi_pkg.sv */
package spbi_pkg;

    localparam int PATH_DEPTH_DEF = 256;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam int SQ_W   = 66;
    localparam int ROOT_W = 33;
    localparam int DVD_W  = 64;
    localparam int DVS_W  = 32;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_RES_FULL,
        OP_RES_EMPTY,
        OP_LWRITE,
        OP_SQ,
        OP_ACC,
        OP_SQRT_START,
        OP_DIV_LOAD,
        OP_LEND,
        OP_IDX_INIT,
        OP_IDX_DEC,
        OP_IDX_INC,
        OP_IDX_FIX,
        OP_SAVE_CUR,
        OP_SAVE_PREV,
        OP_QPREP,
        OP_IMUL,
        OP_DIV_LOAD_I,
        OP_IRES,
        OP_PUBLISH
    } t_dp_op;

    typedef struct packed {
        logic   latch;
        t_dp_op op;
        logic [1:0] axis;
    } t_dp_cmd;

    typedef struct packed {
        logic action;
        logic in_pt;
        logic par_zero;
        logic full;
        logic empty;
        logic idx_gt0;
        logic idx_lt_n;
        logic end_gt_t;
        logic end_lt_t;
        logic skip;
        logic sqrt_done;
        logic div_done;
    } t_dp_status;

endpackage

/* rtl/core/spbi_sqrt.sv */
module spbi_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [spbi_pkg::SQ_W-1:0]     i_radicand,
    output logic                          o_busy,
    output logic [spbi_pkg::ROOT_W-1:0]   o_root
);
    import spbi_pkg::*;

    localparam int CW = $clog2(ROOT_W + 1);

    logic [SQ_W-1:0]   r_op;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic [ROOT_W+3:0] rem_t;
    logic [ROOT_W+3:0] trial;

    assign rem_t = {r_rem, r_op[SQ_W-1 -: 2]};
    assign trial = (ROOT_W+4)'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_op   <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_op <= {r_op[SQ_W-3:0], 2'b00};
            if (rem_t >= trial) begin
                r_rem  <= (ROOT_W+2)'(rem_t - trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= (ROOT_W+2)'(rem_t);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

/* rtl/core/spbi_div.sv */
module spbi_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [spbi_pkg::DVD_W-1:0] i_dividend,
    input  logic [spbi_pkg::DVS_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic [spbi_pkg::DVD_W-1:0] o_quot
);
    import spbi_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [DVS_W:0]   rem_t;

    assign rem_t = {r_rem, r_q[DVD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (rem_t >= {1'b0, r_dvs}) begin
                r_rem <= DVS_W'(rem_t - {1'b0, r_dvs});
                r_q   <= {r_q[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_t[DVS_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(DVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

/* rtl/core/spbi_datapath.sv */
module spbi_datapath #(
    parameter int PATH_DEPTH = spbi_pkg::PATH_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spbi_pkg::t_dp_cmd   i_cmd,
    output spbi_pkg::t_dp_status o_st,
    input  logic                i_action,
    input  logic                i_seg_is_point,
    input  logic signed [31:0]  i_seg_x,
    input  logic signed [31:0]  i_seg_y,
    input  logic signed [31:0]  i_seg_z,
    input  logic [31:0]         i_seg_power,
    input  logic [31:0]         i_seg_param,
    input  logic [31:0]         i_query_time,
    output logic signed [31:0]  o_beam_x,
    output logic signed [31:0]  o_beam_y,
    output logic signed [31:0]  o_beam_z,
    output logic [31:0]         o_beam_power,
    output logic [7:0]          o_segment_index,
    output logic [1:0]          o_status
);
    import spbi_pkg::*;

    localparam int IW = $clog2(PATH_DEPTH);

    logic        m_pt  [PATH_DEPTH];
    logic [31:0] m_x   [PATH_DEPTH];
    logic [31:0] m_y   [PATH_DEPTH];
    logic [31:0] m_z   [PATH_DEPTH];
    logic [31:0] m_pow [PATH_DEPTH];
    logic [31:0] m_par [PATH_DEPTH];
    logic [31:0] m_end [PATH_DEPTH];

    logic        r_in_act, r_in_pt;
    logic [31:0] r_in_x, r_in_y, r_in_z, r_in_pow, r_in_par, r_in_t;
    logic [IW-1:0] r_last, r_cur, r_idx;
    logic [31:0] r_last_x, r_last_y, r_last_z, r_last_end;
    logic        r_rd_zero, r_rd_pt;
    logic [31:0] r_rd_x, r_rd_y, r_rd_z, r_rd_pow, r_rd_par, r_rd_end;
    logic        r_c_pt;
    logic [31:0] r_c_x, r_c_y, r_c_z, r_c_pow, r_c_end;
    logic [31:0] r_p_x, r_p_y, r_p_z, r_p_pow, r_p_end;
    logic [31:0] r_el, r_dt;
    logic        r_neg;
    logic [63:0] r_prod;
    logic [SQ_W-1:0] r_acc;
    logic [31:0] r_res_x, r_res_y, r_res_z, r_res_pow;
    logic [7:0]  r_res_idx;
    logic [1:0]  r_res_st;
    logic [31:0] r_o_x, r_o_y, r_o_z, r_o_pow;
    logic [7:0]  r_o_idx;
    logic [1:0]  r_o_st;

    logic        rd_pt;
    logic [31:0] rd_x, rd_y, rd_z, rd_pow, rd_par, rd_end;
    logic [IW-1:0] slot;
    logic [31:0] sa, sb, ia, ib, pa;
    logic [32:0] sd, id;
    logic [31:0] sq_mag, i_mag, mul_a, mul_b;
    logic [63:0] prod_c;
    logic        sqrt_busy, div_busy, div_start;
    logic [ROOT_W-1:0] root;
    logic [DVD_W-1:0]  quot, dvd;
    logic [DVS_W-1:0]  dvs;
    logic [64:0] add_v, sum_v;
    logic        sat;
    logic [31:0] end_v, el_raw, dt_v;
    logic        t_after;
    logic [IW-1:0] idx_fix;

    function automatic logic [31:0] sel3(input logic [1:0] ax, input logic [31:0] a,
                                         input logic [31:0] b, input logic [31:0] c);
        logic [31:0] v;
        case (ax)
            AX_X:    v = a;
            AX_Y:    v = b;
            default: v = c;
        endcase
        return v;
    endfunction

    assign rd_pt  = r_rd_zero ? 1'b1 : r_rd_pt;
    assign rd_x   = r_rd_zero ? '0 : r_rd_x;
    assign rd_y   = r_rd_zero ? '0 : r_rd_y;
    assign rd_z   = r_rd_zero ? '0 : r_rd_z;
    assign rd_pow = r_rd_zero ? '0 : r_rd_pow;
    assign rd_par = r_rd_zero ? '0 : r_rd_par;
    assign rd_end = r_rd_zero ? '0 : r_rd_end;

    assign slot = r_last + 1'b1;

    assign sa = sel3(i_cmd.axis, r_in_x, r_in_y, r_in_z);
    assign sb = sel3(i_cmd.axis, r_last_x, r_last_y, r_last_z);
    assign sd = {sa[31], sa} - {sb[31], sb};
    assign sq_mag = sd[32] ? 32'(-sd) : sd[31:0];

    assign ia = sel3(i_cmd.axis, r_c_x, r_c_y, r_c_z);
    assign pa = sel3(i_cmd.axis, r_p_x, r_p_y, r_p_z);
    assign ib = pa;
    assign id = {ia[31], ia} - {ib[31], ib};
    assign i_mag = id[32] ? 32'(-id) : id[31:0];

    assign mul_a  = (i_cmd.op == OP_SQ) ? sq_mag : i_mag;
    assign mul_b  = (i_cmd.op == OP_SQ) ? sq_mag : r_el;
    assign prod_c = 64'(mul_a) * 64'(mul_b);

    assign div_start = (i_cmd.op == OP_DIV_LOAD) || (i_cmd.op == OP_DIV_LOAD_I);
    assign dvd = (i_cmd.op == OP_DIV_LOAD) ? DVD_W'({root, 16'h0000}) : r_prod;
    assign dvs = (i_cmd.op == OP_DIV_LOAD) ? r_in_par : r_dt;

    assign add_v = r_in_pt ? 65'(r_in_par) :
                   (r_in_par == '0) ? 65'h1_0000_0000 : 65'(quot);
    assign sum_v = 65'(r_last_end) + add_v;
    assign sat   = |sum_v[64:32];
    assign end_v = sat ? '1 : sum_v[31:0];

    assign t_after = r_in_t > r_p_end;
    assign el_raw  = t_after ? r_in_t - r_p_end : '0;
    assign dt_v    = r_c_end - r_p_end;
    assign idx_fix = (r_idx == '0) ? IW'(1) : r_idx;

    spbi_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_SQRT_START),
        .i_radicand (r_acc),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

    spbi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LWRITE) begin
            m_pt[slot]  <= r_in_pt;
            m_x[slot]   <= r_in_x;
            m_y[slot]   <= r_in_y;
            m_z[slot]   <= r_in_z;
            m_pow[slot] <= r_in_pow;
            m_par[slot] <= r_in_par;
        end
        if (i_cmd.op == OP_LEND) begin
            m_end[slot] <= end_v;
        end
        r_rd_pt  <= m_pt[r_idx];
        r_rd_x   <= m_x[r_idx];
        r_rd_y   <= m_y[r_idx];
        r_rd_z   <= m_z[r_idx];
        r_rd_pow <= m_pow[r_idx];
        r_rd_par <= m_par[r_idx];
        r_rd_end <= m_end[r_idx];
        r_rd_zero <= (r_idx == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_cur      <= '0;
            r_idx      <= '0;
            r_last_x   <= '0;
            r_last_y   <= '0;
            r_last_z   <= '0;
            r_last_end <= '0;
        end else begin
            if (i_cmd.latch) begin
                r_in_act <= i_action;
                r_in_pt  <= i_seg_is_point;
                r_in_x   <= i_seg_x;
                r_in_y   <= i_seg_y;
                r_in_z   <= i_seg_z;
                r_in_pow <= i_seg_power;
                r_in_par <= i_seg_param;
                r_in_t   <= i_query_time;
            end
            case (i_cmd.op)
                OP_RES_FULL: begin
                    r_res_x   <= '0;
                    r_res_y   <= '0;
                    r_res_z   <= '0;
                    r_res_pow <= '0;
                    r_res_idx <= 8'(r_last);
                    r_res_st  <= ST_FULL;
                end
                OP_RES_EMPTY: begin
                    r_res_x   <= '0;
                    r_res_y   <= '0;
                    r_res_z   <= '0;
                    r_res_pow <= '0;
                    r_res_idx <= '0;
                    r_res_st  <= ST_EMPTY;
                end
                OP_LWRITE: begin
                    r_acc <= '0;
                end
                OP_SQ, OP_IMUL: begin
                    r_prod <= prod_c;
                    r_neg  <= id[32];
                end
                OP_ACC: begin
                    r_acc <= r_acc + SQ_W'(r_prod);
                end
                OP_LEND: begin
                    r_last     <= slot;
                    r_last_x   <= r_in_x;
                    r_last_y   <= r_in_y;
                    r_last_z   <= r_in_z;
                    r_last_end <= end_v;
                    r_res_x    <= '0;
                    r_res_y    <= '0;
                    r_res_z    <= '0;
                    r_res_pow  <= '0;
                    r_res_idx  <= 8'(slot);
                    r_res_st   <= sat ? ST_SAT : ST_OK;
                end
                OP_IDX_INIT: begin
                    r_idx <= (r_cur > r_last) ? r_last : r_cur;
                end
                OP_IDX_DEC: begin
                    r_idx <= r_idx - 1'b1;
                end
                OP_IDX_INC: begin
                    r_idx <= r_idx + 1'b1;
                end
                OP_IDX_FIX: begin
                    r_idx <= idx_fix;
                    r_cur <= idx_fix;
                end
                OP_SAVE_CUR: begin
                    r_c_pt    <= rd_pt;
                    r_c_x     <= rd_x;
                    r_c_y     <= rd_y;
                    r_c_z     <= rd_z;
                    r_c_pow   <= rd_pow;
                    r_c_end   <= rd_end;
                    r_res_idx <= 8'(r_idx);
                    r_idx     <= r_idx - 1'b1;
                end
                OP_SAVE_PREV: begin
                    r_p_x   <= rd_x;
                    r_p_y   <= rd_y;
                    r_p_z   <= rd_z;
                    r_p_pow <= rd_pow;
                    r_p_end <= rd_end;
                end
                OP_QPREP: begin
                    r_dt      <= dt_v;
                    r_el      <= (el_raw > dt_v) ? dt_v : el_raw;
                    r_res_pow <= t_after ? r_c_pow : r_p_pow;
                    r_res_st  <= ST_OK;
                end
                OP_IRES: begin
                    case (i_cmd.axis)
                        AX_X: begin
                            r_res_x <= r_c_pt ? ia : (r_dt == '0) ? pa :
                                       r_neg ? pa - quot[31:0] : pa + quot[31:0];
                        end
                        AX_Y: begin
                            r_res_y <= r_c_pt ? ia : (r_dt == '0) ? pa :
                                       r_neg ? pa - quot[31:0] : pa + quot[31:0];
                        end
                        default: begin
                            r_res_z <= r_c_pt ? ia : (r_dt == '0) ? pa :
                                       r_neg ? pa - quot[31:0] : pa + quot[31:0];
                        end
                    endcase
                end
                OP_PUBLISH: begin
                    r_o_x   <= r_res_x;
                    r_o_y   <= r_res_y;
                    r_o_z   <= r_res_z;
                    r_o_pow <= r_res_pow;
                    r_o_idx <= r_res_idx;
                    r_o_st  <= r_res_st;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_st.action    = r_in_act;
        o_st.in_pt     = r_in_pt;
        o_st.par_zero  = (r_in_par == '0);
        o_st.full      = (r_last == IW'(PATH_DEPTH - 1));
        o_st.empty     = (r_last == '0);
        o_st.idx_gt0   = (r_idx != '0);
        o_st.idx_lt_n  = (r_idx < r_last);
        o_st.end_gt_t  = (rd_end > r_in_t);
        o_st.end_lt_t  = (rd_end < r_in_t);
        o_st.skip      = rd_pt && (rd_par == '0);
        o_st.sqrt_done = !sqrt_busy;
        o_st.div_done  = !div_busy;
    end

    assign o_beam_x        = r_o_x;
    assign o_beam_y        = r_o_y;
    assign o_beam_z        = r_o_z;
    assign o_beam_power    = r_o_pow;
    assign o_segment_index = r_o_idx;
    assign o_status        = r_o_st;

endmodule

/* rtl/core/spbi_ctrl.sv */
module spbi_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  spbi_pkg::t_dp_status  i_st,
    output spbi_pkg::t_dp_cmd     o_cmd
);
    import spbi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_RES_FULL, S_RES_EMPTY,
        S_L_WRITE, S_L_SQ, S_L_ACC, S_L_SQRT_GO, S_L_SQRT_WAIT,
        S_L_DIV_GO, S_L_DIV_WAIT, S_L_END,
        S_Q_INIT, S_Q_BACK_RD, S_Q_BACK, S_Q_FWD_RD, S_Q_FWD,
        S_Q_SKIP_RD, S_Q_SKIP, S_Q_FIX, S_Q_CUR_RD, S_Q_CUR,
        S_Q_PREV_RD, S_Q_PREV, S_Q_PREP, S_Q_MUL, S_Q_DIV_GO,
        S_Q_DIV_WAIT, S_Q_RES, S_PUBLISH
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.latch = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.axis  = r_axis;
        case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_st.action) begin
                    n_state = i_st.full ? S_RES_FULL : S_L_WRITE;
                end else begin
                    n_state = i_st.empty ? S_RES_EMPTY : S_Q_INIT;
                end
            end
            S_RES_FULL: begin
                o_cmd.op = OP_RES_FULL;
                n_state  = S_PUBLISH;
            end
            S_RES_EMPTY: begin
                o_cmd.op = OP_RES_EMPTY;
                n_state  = S_PUBLISH;
            end
            S_L_WRITE: begin
                o_cmd.op = OP_LWRITE;
                n_axis   = AX_X;
                n_state  = (i_st.in_pt || i_st.par_zero) ? S_L_END : S_L_SQ;
            end
            S_L_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = S_L_ACC;
            end
            S_L_ACC: begin
                o_cmd.op = OP_ACC;
                if (r_axis == AX_Z) begin
                    n_state = S_L_SQRT_GO;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_L_SQ;
                end
            end
            S_L_SQRT_GO: begin
                o_cmd.op = OP_SQRT_START;
                n_state  = S_L_SQRT_WAIT;
            end
            S_L_SQRT_WAIT: begin
                if (i_st.sqrt_done) begin
                    n_state = S_L_DIV_GO;
                end
            end
            S_L_DIV_GO: begin
                o_cmd.op = OP_DIV_LOAD;
                n_state  = S_L_DIV_WAIT;
            end
            S_L_DIV_WAIT: begin
                if (i_st.div_done) begin
                    n_state = S_L_END;
                end
            end
            S_L_END: begin
                o_cmd.op = OP_LEND;
                n_state  = S_PUBLISH;
            end
            S_Q_INIT: begin
                o_cmd.op = OP_IDX_INIT;
                n_state  = S_Q_BACK_RD;
            end
            S_Q_BACK_RD: begin
                n_state = S_Q_BACK;
            end
            S_Q_BACK: begin
                if (i_st.idx_gt0 && i_st.end_gt_t) begin
                    o_cmd.op = OP_IDX_DEC;
                    n_state  = S_Q_BACK_RD;
                end else begin
                    n_state = S_Q_FWD;
                end
            end
            S_Q_FWD_RD: begin
                n_state = S_Q_FWD;
            end
            S_Q_FWD: begin
                if (i_st.idx_lt_n && i_st.end_lt_t) begin
                    o_cmd.op = OP_IDX_INC;
                    n_state  = S_Q_FWD_RD;
                end else begin
                    n_state = S_Q_SKIP;
                end
            end
            S_Q_SKIP_RD: begin
                n_state = S_Q_SKIP;
            end
            S_Q_SKIP: begin
                if (i_st.idx_lt_n && i_st.skip) begin
                    o_cmd.op = OP_IDX_INC;
                    n_state  = S_Q_SKIP_RD;
                end else begin
                    n_state = S_Q_FIX;
                end
            end
            S_Q_FIX: begin
                o_cmd.op = OP_IDX_FIX;
                n_state  = S_Q_CUR_RD;
            end
            S_Q_CUR_RD: begin
                n_state = S_Q_CUR;
            end
            S_Q_CUR: begin
                o_cmd.op = OP_SAVE_CUR;
                n_state  = S_Q_PREV_RD;
            end
            S_Q_PREV_RD: begin
                n_state = S_Q_PREV;
            end
            S_Q_PREV: begin
                o_cmd.op = OP_SAVE_PREV;
                n_state  = S_Q_PREP;
            end
            S_Q_PREP: begin
                o_cmd.op = OP_QPREP;
                n_axis   = AX_X;
                n_state  = S_Q_MUL;
            end
            S_Q_MUL: begin
                o_cmd.op = OP_IMUL;
                n_state  = S_Q_DIV_GO;
            end
            S_Q_DIV_GO: begin
                o_cmd.op = OP_DIV_LOAD_I;
                n_state  = S_Q_DIV_WAIT;
            end
            S_Q_DIV_WAIT: begin
                if (i_st.div_done) begin
                    n_state = S_Q_RES;
                end
            end
            S_Q_RES: begin
                o_cmd.op = OP_IRES;
                if (r_axis == AX_Z) begin
                    n_state = S_PUBLISH;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_Q_MUL;
                end
            end
            S_PUBLISH: begin
                if (!r_out_valid) begin
                    o_cmd.op    = OP_PUBLISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AX_X;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/scan_path_beam_interpolator_unit.sv */
// One item is handled at a time; the next is taken once the result is in the output register.
// A load of a point or of a zero-speed line skips the arithmetic; a line load runs a square root
// and then a division. A query walks the table one index step at a time, then runs three
// interpolation divisions, one per axis.
// Synchronous active-low reset clears control state and the path to a single origin point;
// table entries other than the first are undefined until written, and no clearing pass runs.
module scan_path_beam_interpolator_unit #(
    parameter int PATH_DEPTH = spbi_pkg::PATH_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic               i_seg_is_point,
    input  logic signed [31:0] i_seg_x,
    input  logic signed [31:0] i_seg_y,
    input  logic signed [31:0] i_seg_z,
    input  logic [31:0]        i_seg_power,
    input  logic [31:0]        i_seg_param,
    input  logic [31:0]        i_query_time,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_beam_x,
    output logic signed [31:0] o_beam_y,
    output logic signed [31:0] o_beam_z,
    output logic [31:0]        o_beam_power,
    output logic [7:0]         o_segment_index,
    output logic [1:0]         o_status
);
    import spbi_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status st;

    spbi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    spbi_datapath #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_action        (i_action),
        .i_seg_is_point  (i_seg_is_point),
        .i_seg_x         (i_seg_x),
        .i_seg_y         (i_seg_y),
        .i_seg_z         (i_seg_z),
        .i_seg_power     (i_seg_power),
        .i_seg_param     (i_seg_param),
        .i_query_time    (i_query_time),
        .o_beam_x        (o_beam_x),
        .o_beam_y        (o_beam_y),
        .o_beam_z        (o_beam_z),
        .o_beam_power    (o_beam_power),
        .o_segment_index (o_segment_index),
        .o_status        (o_status)
    );

    a_sqrt_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_SQRT_START |-> st.sqrt_done)
        else $error("square root started while busy");

    a_div_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_DIV_LOAD || cmd.op == OP_DIV_LOAD_I) |-> st.div_done)
        else $error("division started while busy");

    a_accept_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> (st.div_done && st.sqrt_done))
        else $error("item accepted while an arithmetic unit is busy");

    a_publish_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_PUBLISH |-> !o_out_valid)
        else $error("result published over a pending item");

endmodule

/* bench/scan_path_beam_interpolator_unit_tb.sv */
`timescale 1ns / 100ps

module scan_path_beam_interpolator_unit_tb;
    import spbi_pkg::*;

    localparam int          SLOTS       = PATH_DEPTH_DEF;
    localparam logic        ACT_LOAD    = 1'b0;
    localparam logic        ACT_QUERY   = 1'b1;
    localparam int          RANDOM_ITEMS = 620;
    localparam int          LOAD_CAP    = 250;
    localparam int          CYCLE_LIMIT = 3000000;

    typedef struct {
        logic               action;
        logic               is_point;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        power;
        logic [31:0]        param;
        logic [31:0]        qtime;
    } t_beam_item;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        power;
        logic [7:0]         index;
        logic [1:0]         status;
    } t_beam_state;

    class t_beam_path_scoreboard;
        logic        pt_flag [SLOTS];
        logic [31:0] pos_x [SLOTS];
        logic [31:0] pos_y [SLOTS];
        logic [31:0] pos_z [SLOTS];
        logic [31:0] pow [SLOTS];
        logic [31:0] dwell_speed [SLOTS];
        logic [31:0] end_time [SLOTS];
        int unsigned last_slot;
        int unsigned cur_index;
        t_beam_state expected_beam_q [$];
        int          errors;
        int          loads_seen;
        int          queries_seen;
        int          full_seen;
        int          sat_seen;
        int          empty_seen;

        function new();
            for (int k = 0; k < SLOTS; k++) begin
                pt_flag[k] = 1'b0;
                pos_x[k] = '0;
                pos_y[k] = '0;
                pos_z[k] = '0;
                pow[k] = '0;
                dwell_speed[k] = '0;
                end_time[k] = '0;
            end
            pt_flag[0] = 1'b1;
            last_slot = 0;
            cur_index = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_beam_q.size();
        endfunction

        function logic [31:0] path_end();
            return end_time[last_slot];
        endfunction

        function logic [32:0] abs_gap(logic [31:0] a, logic [31:0] b);
            logic signed [33:0] d;
            d = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
            return d < 0 ? 33'(-d) : 33'(d);
        endfunction

        function logic [34:0] span_length(int unsigned p, int unsigned q);
            logic [65:0] sum;
            logic [32:0] m;
            logic [34:0] r;
            logic [34:0] c;
            logic [69:0] cw;
            m = abs_gap(pos_x[p], pos_x[q]);
            sum = 66'(m) * 66'(m);
            m = abs_gap(pos_y[p], pos_y[q]);
            sum = sum + 66'(m) * 66'(m);
            m = abs_gap(pos_z[p], pos_z[q]);
            sum = sum + 66'(m) * 66'(m);
            r = '0;
            for (int b = 34; b >= 0; b--) begin
                c = r | (35'd1 << b);
                cw = 70'(c);
                if (cw * cw <= 70'(sum))
                    r = c;
            end
            return r;
        endfunction

        function logic [31:0] blend(logic [31:0] p0, logic [31:0] p1,
                                    logic [63:0] el, logic [63:0] dt);
            logic signed [65:0] a;
            logic signed [65:0] d;
            logic [95:0]        mag;
            logic [95:0]        q;
            if (dt == 0)
                return p0;
            a = $signed({{34{p0[31]}}, p0});
            d = $signed({{34{p1[31]}}, p1}) - a;
            mag = d < 0 ? 96'(-d) : 96'(d);
            q = (mag * 96'(el)) / 96'(dt);
            a = d < 0 ? a - $signed(66'(q)) : a + $signed(66'(q));
            return a[31:0];
        endfunction

        function void note_item(t_beam_item it);
            t_beam_state e;
            int unsigned n;
            int unsigned s;
            int unsigned i;
            int unsigned prev;
            logic [63:0] add;
            logic [63:0] fin;
            logic [63:0] el;
            logic [63:0] dt;
            e = '{x: 0, y: 0, z: 0, power: 0, index: 0, status: ST_OK};
            n = last_slot;
            if (it.action == ACT_LOAD) begin
                loads_seen++;
                s = n + 1;
                if (s >= SLOTS) begin
                    e.index = n[7:0];
                    e.status = ST_FULL;
                    full_seen++;
                end else begin
                    pt_flag[s] = it.is_point;
                    pos_x[s] = it.x;
                    pos_y[s] = it.y;
                    pos_z[s] = it.z;
                    pow[s] = it.power;
                    dwell_speed[s] = it.param;
                    if (it.is_point)
                        add = 64'(it.param);
                    else if (it.param == 0)
                        add = 64'h1_0000_0000;
                    else
                        add = {13'd0, span_length(s, n), 16'd0} / 64'(it.param);
                    fin = 64'(end_time[n]) + add;
                    if (fin > 64'hFFFF_FFFF) begin
                        fin = 64'hFFFF_FFFF;
                        e.status = ST_SAT;
                        sat_seen++;
                    end
                    end_time[s] = fin[31:0];
                    last_slot = s;
                    e.index = s[7:0];
                end
            end else begin
                queries_seen++;
                if (n == 0) begin
                    e.status = ST_EMPTY;
                    empty_seen++;
                end else begin
                    i = cur_index > n ? n : cur_index;
                    while (i > 0 && end_time[i] > it.qtime)
                        i--;
                    while (i < n && end_time[i] < it.qtime)
                        i++;
                    while (i < n && pt_flag[i] && dwell_speed[i] == 0)
                        i++;
                    if (i < 1)
                        i = 1;
                    cur_index = i;
                    prev = i - 1;
                    if (it.qtime > end_time[prev]) begin
                        el = 64'(it.qtime) - 64'(end_time[prev]);
                        e.power = pow[i];
                    end else begin
                        el = 0;
                        e.power = pow[prev];
                    end
                    if (pt_flag[i]) begin
                        e.x = pos_x[i];
                        e.y = pos_y[i];
                        e.z = pos_z[i];
                    end else begin
                        dt = 64'(end_time[i]) - 64'(end_time[prev]);
                        if (el > dt)
                            el = dt;
                        e.x = blend(pos_x[prev], pos_x[i], el, dt);
                        e.y = blend(pos_y[prev], pos_y[i], el, dt);
                        e.z = blend(pos_z[prev], pos_z[i], el, dt);
                    end
                    e.index = i[7:0];
                end
            end
            expected_beam_q.insert(expected_beam_q.size(), e);
        endfunction

        function void check_result(t_beam_state got);
            t_beam_state e;
            if (expected_beam_q.size() == 0) begin
                $display("%0t: unexpected result, index %h status %h", $time,
                         got.index, got.status);
                errors++;
                return;
            end
            e = expected_beam_q.pop_front();
            if (got.x !== e.x) begin
                $display("%0t: beam_x expected %h actual %h", $time, e.x, got.x);
                errors++;
            end
            if (got.y !== e.y) begin
                $display("%0t: beam_y expected %h actual %h", $time, e.y, got.y);
                errors++;
            end
            if (got.z !== e.z) begin
                $display("%0t: beam_z expected %h actual %h", $time, e.z, got.z);
                errors++;
            end
            if (got.power !== e.power) begin
                $display("%0t: beam_power expected %h actual %h", $time, e.power,
                         got.power);
                errors++;
            end
            if (got.index !== e.index) begin
                $display("%0t: segment_index expected %h actual %h", $time, e.index,
                         got.index);
                errors++;
            end
            if (got.status !== e.status) begin
                $display("%0t: status expected %h actual %h", $time, e.status,
                         got.status);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_action = 1'b0;
    logic               i_seg_is_point = 1'b0;
    logic signed [31:0] i_seg_x = '0;
    logic signed [31:0] i_seg_y = '0;
    logic signed [31:0] i_seg_z = '0;
    logic [31:0]        i_seg_power = '0;
    logic [31:0]        i_seg_param = '0;
    logic [31:0]        i_query_time = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_beam_x;
    logic signed [31:0] o_beam_y;
    logic signed [31:0] o_beam_z;
    logic [31:0]        o_beam_power;
    logic [7:0]         o_segment_index;
    logic [1:0]         o_status;

    t_beam_path_scoreboard beam_sb = new();
    int                  loads_sent = 0;
    int                  items_sent = 0;
    int                  results_taken = 0;
    bit                  send_busy = 1'b1;

    scan_path_beam_interpolator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_seg_is_point (i_seg_is_point),
        .i_seg_x        (i_seg_x),
        .i_seg_y        (i_seg_y),
        .i_seg_z        (i_seg_z),
        .i_seg_power    (i_seg_power),
        .i_seg_param    (i_seg_param),
        .i_query_time   (i_query_time),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_beam_x       (o_beam_x),
        .o_beam_y       (o_beam_y),
        .o_beam_z       (o_beam_z),
        .o_beam_power   (o_beam_power),
        .o_segment_index(o_segment_index),
        .o_status       (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_beam_item load_item(logic pt, logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z, logic [31:0] pw,
                                             logic [31:0] par);
        return '{action: ACT_LOAD, is_point: pt, x: x, y: y, z: z, power: pw,
                 param: par, qtime: $urandom};
    endfunction

    function automatic t_beam_item query_item(logic [31:0] t);
        return '{action: ACT_QUERY, is_point: 1'($urandom_range(0, 1)), x: $urandom,
                 y: $urandom, z: $urandom, power: $urandom, param: $urandom, qtime: t};
    endfunction

    function automatic logic [31:0] near_coord();
        return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
    endfunction

    function automatic t_beam_item random_load();
        logic pt;
        logic [31:0] par;
        pt = ($urandom_range(0, 4) < 2);
        if (pt)
            par = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 32'h3_0000));
        else
            par = $urandom_range(32'h8000, 32'hFFFF_FFFF);
        return load_item(pt, near_coord(), near_coord(), near_coord(), $urandom, par);
    endfunction

    function automatic t_beam_item random_query();
        logic [63:0] top;
        if ($urandom_range(0, 9) == 0)
            return query_item($urandom);
        top = 64'(beam_sb.path_end()) + 64'h2_0000;
        if (top > 64'hFFFF_FFFF)
            top = 64'hFFFF_FFFF;
        return query_item($urandom_range(0, top[31:0]));
    endfunction

    task automatic send_item(t_beam_item it);
        int gap;
        if (items_sent % 40 == 0)
            send_busy = ($urandom_range(0, 2) != 0);
        gap = send_busy ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= it.action;
        i_seg_is_point <= it.is_point;
        i_seg_x        <= it.x;
        i_seg_y        <= it.y;
        i_seg_z        <= it.z;
        i_seg_power    <= it.power;
        i_seg_param    <= it.param;
        i_query_time   <= it.qtime;
        do @(posedge i_clk); while (!o_in_ready);
        beam_sb.note_item(it);
        items_sent++;
        if (it.action == ACT_LOAD)
            loads_sent++;
    endtask

    initial begin
        int  gap;
        bit  held;
        bit  busy;
        held = 1'b0;
        busy = 1'b1;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (results_taken % 50 == 0)
                busy = ($urandom_range(0, 2) != 0);
            gap = busy ? $urandom_range(0, 18) : 0;
            if (results_taken == 40 && !held) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (700) @(posedge i_clk);
            end else if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            beam_sb.check_result('{x: o_beam_x, y: o_beam_y, z: o_beam_z,
                                   power: o_beam_power, index: o_segment_index,
                                   status: o_status});
            results_taken++;
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Queries on the bare origin point report an empty path.
        send_item(query_item(32'd0));
        send_item(query_item(32'hFFFF_FFFF));
        send_item(load_item(1'b1, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'hFFFF_FFFF,
                            32'h1_0000));
        send_item(load_item(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 32'd0));
        send_item(load_item(1'b0, 32'd0, 32'd0, 32'd0, 32'h5_0000, 32'hFFFF_FFFF));
        send_item(load_item(1'b0, 32'h3_0000, 32'hFFFC_0000, 32'h5_0000, 32'h1234_5678,
                            32'h1_0000));
        send_item(load_item(1'b0, 32'h3_0000, 32'hFFFC_0000, 32'h5_0000, 32'h0000_0001,
                            32'd1));
        send_item(load_item(1'b0, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000,
                            32'hA5A5_5A5A, 32'h8000));
        send_item(query_item(32'd0));
        send_item(query_item(32'h8000));
        send_item(query_item(32'h1_0000));
        send_item(query_item(32'h1_0001));
        send_item(query_item(beam_sb.end_time[5] + 32'd3));
        send_item(query_item(beam_sb.end_time[6]));
        send_item(query_item(beam_sb.end_time[7] - 32'd7));
        send_item(query_item(32'hFFFF_FFFF));
        send_item(query_item(32'd1));

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 300) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (beam_sb.pending() != 0);
            end
            if (loads_sent < LOAD_CAP && $urandom_range(0, 99) < 55)
                send_item(random_load());
            else
                send_item(random_query());
        end

        while (loads_sent < LOAD_CAP)
            send_item(random_load());
        send_item(random_query());
        send_item(load_item(1'b0, near_coord(), near_coord(), near_coord(), $urandom,
                            32'd0));
        send_item(random_query());
        send_item(load_item(1'b1, $urandom, $urandom, $urandom, $urandom,
                            32'hFFFF_FFFF));
        send_item(load_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            $urandom, 32'd1));
        while (loads_sent < SLOTS + 3)
            send_item(load_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                                $urandom, $urandom));
        send_item(query_item(32'hFFFF_FFFF));
        send_item(query_item(32'd0));
        repeat (10) send_item(query_item($urandom));
        i_in_valid <= 1'b0;

        while (beam_sb.pending() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("Covered %0d loads and %0d queries: %0d table-full, %0d saturated,",
                 beam_sb.loads_seen, beam_sb.queries_seen, beam_sb.full_seen,
                 beam_sb.sat_seen);
        $display("%0d empty-path results; %0d mismatches.", beam_sb.empty_seen,
                 beam_sb.errors);
        if (beam_sb.errors == 0 && beam_sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
